// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl engine file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("property failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/scm_pkg.sv =====
// types and constants of the string compare block
package scm_pkg;

  localparam int INDEX_WIDTH = 16;
  localparam int OFS_WIDTH   = 16;
  localparam int IDX_OUT_W   = 16;
  localparam int EXT_WIDTH   = (INDEX_WIDTH > OFS_WIDTH) ? INDEX_WIDTH : OFS_WIDTH;
  localparam logic [INDEX_WIDTH-1:0] POS_MAX = {INDEX_WIDTH{1'b1}};

  localparam int ADDR_WIDTH = 4;
  localparam int DATA_WIDTH = 32;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_FOLD   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  // compare modes
  localparam logic [2:0] MODE_LT = 3'd0;
  localparam logic [2:0] MODE_LE = 3'd1;
  localparam logic [2:0] MODE_EQ = 3'd2;
  localparam logic [2:0] MODE_NE = 3'd3;
  localparam logic [2:0] MODE_GE = 3'd4;
  localparam logic [2:0] MODE_GT = 3'd5;

  typedef struct packed {
    logic       first_pair;
    logic       a_present;
    logic [7:0] char_a;
    logic       b_present;
    logic [7:0] char_b;
  } scm_in_t;

  typedef struct packed {
    logic                 verdict;
    logic [IDX_OUT_W-1:0] decide_index;
  } scm_out_t;

  typedef struct packed {
    logic [2:0]           compare_mode;
    logic                 fold_case;
    logic [OFS_WIDTH-1:0] start_offset;
  } scm_cfg_t;

endpackage

// ===== rtl/string_compare_mismatch_core.sv =====
// String compare core: takes one character pair per item and gives at most one result
// per comparison. Sustains one item per clock cycle while the output is not stalled; an
// item's result passes from the input register through the single compare stage into the
// result register. While a result waits on a stalled output the input register holds at
// most one more item, then the input stalls. The user must write configuration through
// the apb-style port only while the block is idle; the block itself does not enforce
// this. There is no clearing pass after reset.
module string_compare_mismatch_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  scm_pkg::scm_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output scm_pkg::scm_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scm_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [scm_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [scm_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready
);
  import scm_pkg::*;

  scm_cfg_t cfg;
  scm_in_t  in_r;
  scm_out_t res, out_r;
  logic     in_vld_r, in_vld_nxt;
  logic     out_vld_r, out_vld_nxt;
  logic     out_free, go, emit, accept;

  scm_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scm_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .go_i   (go),
    .item_i (in_r),
    .cfg_i  (cfg),
    .emit_o (emit),
    .res_o  (res)
  );

  assign out_free = !out_vld_r || !out_stall;
  assign go       = in_vld_r && out_free;
  assign in_stall = in_vld_r && !go;
  assign accept   = in_valid && !in_stall;

  assign in_vld_nxt  = accept || (in_vld_r && !go);
  assign out_vld_nxt = (out_vld_r && out_stall) || (go && emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (go && emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/scm_cfg_regs.sv =====
// configuration registers behind the apb-style port
module scm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scm_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [scm_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [scm_pkg::DATA_WIDTH-1:0] prdata,
  output logic                         pready,
  output scm_pkg::scm_cfg_t            cfg_o
);
  import scm_pkg::*;

  scm_cfg_t cfg_r, cfg_nxt;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_MODE:   cfg_nxt.compare_mode = pwdata[2:0];
        REG_FOLD:   cfg_nxt.fold_case    = pwdata[0];
        REG_OFFSET: cfg_nxt.start_offset = pwdata[OFS_WIDTH-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = DATA_WIDTH'(cfg_r.compare_mode);
      REG_FOLD:   prdata = DATA_WIDTH'(cfg_r.fold_case);
      REG_OFFSET: prdata = DATA_WIDTH'(cfg_r.start_offset);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_r;

endmodule

// ===== rtl/scm_engine.sv =====
// per-item compare logic with position and decided state
`include "assert_macros.svh"

module scm_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go_i,
  input  scm_pkg::scm_in_t  item_i,
  input  scm_pkg::scm_cfg_t cfg_i,
  output logic              emit_o,
  output scm_pkg::scm_out_t res_o
);
  import scm_pkg::*;

  logic [INDEX_WIDTH-1:0] pos_r, pos_nxt;
  logic                   decided_r, decided_nxt;
  logic [INDEX_WIDTH-1:0] pos_cur;
  logic                   decided_cur;
  logic [EXT_WIDTH-1:0]   ofs_ext;
  logic [INDEX_WIDTH-1:0] ofs_sat;
  logic [EXT_WIDTH-1:0]   pos_ext;
  logic [7:0]             a_f, b_f;
  logic                   ea, eb, lt, gt, both;
  logic                   verdict;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    if (en && c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // saturate the offset to the position range
  assign ofs_ext = EXT_WIDTH'(cfg_i.start_offset);
  assign ofs_sat = (ofs_ext > EXT_WIDTH'(POS_MAX)) ? POS_MAX : INDEX_WIDTH'(ofs_ext);

  assign pos_cur     = item_i.first_pair ? ofs_sat : pos_r;
  assign decided_cur = item_i.first_pair ? 1'b0 : decided_r;

  assign ea   = !item_i.a_present;
  assign eb   = !item_i.b_present;
  assign both = !ea && !eb;
  assign a_f  = fold_char(item_i.char_a, cfg_i.fold_case);
  assign b_f  = fold_char(item_i.char_b, cfg_i.fold_case);
  assign lt   = a_f < b_f;
  assign gt   = a_f > b_f;

  always_comb begin
    verdict = 1'b0;
    if (both) begin
      case (cfg_i.compare_mode)
        MODE_LT: verdict = lt;
        MODE_LE: verdict = !gt;
        MODE_NE: verdict = 1'b1;
        MODE_GE: verdict = !lt;
        MODE_GT: verdict = gt;
        default: verdict = 1'b0;
      endcase
    end else begin
      case (cfg_i.compare_mode)
        MODE_LT: verdict = ea && !eb;
        MODE_LE: verdict = ea;
        MODE_EQ: verdict = ea && eb;
        MODE_NE: verdict = !(ea && eb);
        MODE_GE: verdict = eb;
        MODE_GT: verdict = eb && !ea;
        default: verdict = 1'b0;
      endcase
    end
  end

  // a matching pair gives nothing, anything else decides unless already decided
  assign emit_o = !decided_cur && !(both && !lt && !gt);

  assign pos_ext            = EXT_WIDTH'(pos_cur);
  assign res_o.verdict      = verdict;
  assign res_o.decide_index = (cfg_i.compare_mode == MODE_EQ) ? '0 : IDX_OUT_W'(pos_ext);

  always_comb begin
    pos_nxt     = pos_r;
    decided_nxt = decided_r;
    if (go_i) begin
      pos_nxt     = pos_cur;
      decided_nxt = decided_cur || emit_o;
      if (!decided_cur && !emit_o && pos_cur != POS_MAX) begin
        pos_nxt = pos_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      decided_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      decided_r <= decided_nxt;
    end
  end

  `ASSERT_PROP(a_emit_sets_decided, clk, rst_n, go_i && emit_o |=> decided_r)
  `ASSERT_NEVER(a_no_emit_when_done, clk, rst_n,
                decided_r && !item_i.first_pair && emit_o)
  `ASSERT_PROP(a_pos_monotonic, clk, rst_n,
               go_i && !item_i.first_pair |=> pos_r >= $past(pos_r))
  `ASSERT_PROP(a_start_clears, clk, rst_n,
               go_i && item_i.first_pair && !emit_o |=> !decided_r)

endmodule
